[rtl/core/bfd_pkg.sv]
`default_nettype none
package bfd_pkg;

    localparam int MAX_RADIUS_DEF = 4;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int WEIGHT_BITS    = 16;
    localparam int WSHIFT         = 31 - WEIGHT_BITS;
    localparam int WMAX           = (1 << WEIGHT_BITS) - 1;
    localparam int NUM_W          = 32;
    localparam int DEN_W          = 24;
    localparam int POS_W          = 26;
    localparam int ROW_W          = 12;
    localparam int DIM_W          = 13;
    localparam int QUO_W          = 8;

    typedef enum logic [1:0] {
        REQ_PIXEL   = 2'd0,
        REQ_RANGE   = 2'd1,
        REQ_SPATIAL = 2'd2,
        REQ_FLUSH   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTER,
        ST_CWAIT,
        ST_TAP,
        ST_QREAD,
        ST_RREAD,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

[rtl/core/bfd_div.sv]
`default_nettype none
module bfd_div #(
    parameter int NUM_BITS = bfd_pkg::NUM_W,
    parameter int DEN_BITS = bfd_pkg::DEN_W,
    parameter int Q_BITS   = bfd_pkg::QUO_W
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [Q_BITS-1:0]        quo
);
    import bfd_pkg::*;

    localparam int CNT_W = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;
    localparam int EXT_W = NUM_BITS + Q_BITS;

    logic [NUM_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [Q_BITS-1:0]   quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [EXT_W-1:0]    shifted;
    logic                fits;

    // restoring division, one quotient bit per cycle, quotient known to fit
    assign shifted = EXT_W'(den_reg) << cnt_reg;
    assign fits    = EXT_W'(rem_reg) >= shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
            cnt_reg <= CNT_W'(Q_BITS - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg          <= rem_reg - NUM_BITS'(shifted);
                quo_reg[cnt_reg] <= 1'b1;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

[rtl/core/bilateral_filter_diamond.sv]
`default_nettype none
// Streaming bilateral filter over a diamond window, 8-bit grey pixels in raster
// order, one item at a time. Weight loads and items that produce no filtered
// pixel leave the input ready. An item that produces a pixel walks the window,
// which holds 2*r*r+2*r+1 taps, some inside the image and some outside it. The
// line store has a single read port, and each inside tap goes through line
// read, range table read, weight multiply and accumulate. An outside tap is
// skipped. Closing the walk starts an 8-step divider that forms the quotient.
// The input is not ready while an item is being filtered or its result is
// pending, in the cycle after a configuration write and in the first cycle
// after reset. No clearing pass.
module bilateral_filter_diamond #(
    parameter int MAX_RADIUS = bfd_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_table_index,
    input  wire logic [15:0] s_weight_value,
    input  wire logic [7:0]  s_pixel_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_pixel_out,
    output logic [11:0]      m_out_row,
    output logic [9:0]       m_out_col,
    output logic             m_frame_end
);
    import bfd_pkg::*;

    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int RING_W = $clog2(RING);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int DW     = RW + 2;
    localparam int AW     = $clog2(RING * MAX_WIDTH);
    localparam int SW     = 16;

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [RW-1:0]    radius_reg;
    logic [POS_W-1:0] total_reg, lag_reg;
    logic             pend_reg;
    logic [10:0]      cfg_w;
    logic [12:0]      cfg_h;
    logic [2:0]       cfg_r;

    // stream position
    logic [POS_W-1:0]  pos_reg;
    logic [CW-1:0]     col_reg;
    logic [RING_W-1:0] in_ring_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [CW-1:0]     out_col_reg;
    logic [RING_W-1:0] out_ring_reg;

    // current center
    logic [ROW_W-1:0]  cr_reg;
    logic [CW-1:0]     cc_reg;
    logic [RING_W-1:0] cring_reg;
    logic              fe_reg;

    // tap walk
    state_t             state_reg, state_next;
    logic signed [DW-1:0] dr_reg, dc_reg;
    logic               tap_done_reg;
    logic [RW-1:0]      d_reg;
    logic [7:0]         p_reg, q_reg;
    logic [31:0]        prod_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;

    // storage
    logic [7:0]  ls_mem [RING*MAX_WIDTH];
    logic [7:0]  ls_rdata_reg;
    logic [AW-1:0] ls_raddr, ls_waddr;
    logic [15:0] rt_mem [256];
    logic [15:0] rt_rdata_reg;
    logic [7:0]  rt_raddr;
    logic [15:0] st_reg [MAX_RADIUS+1];

    // output
    logic [7:0]       pix_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [CW-1:0]    ocol_reg;
    logic             ofe_reg;

    logic             in_xfer, in_frame, step_ok, stream_step, start_filter, fe;
    req_t             kind;
    logic             div_start, div_done;
    logic [QUO_W-1:0] div_quo;

    logic signed [SW-1:0] dr_x, dc_x, dr_abs, dc_abs, span, dr1, dr1_abs;
    logic signed [SW-1:0] qr, qc, ring, ring_w;
    logic                 tap_in;
    logic [RW-1:0]        tap_d;
    logic signed [DW-1:0] dr_next, dc_next;
    logic                 done_next;
    logic [AW-1:0]        tap_addr, ctr_addr;
    logic [31:0]          w_full;
    logic [WEIGHT_BITS-1:0] w;

    assign kind         = req_t'(s_req_type);
    assign s_ready      = (state_reg == ST_IDLE) && !pend_reg;
    assign in_xfer      = s_valid && s_ready;
    assign in_frame     = pos_reg < total_reg;
    assign step_ok      = (kind == REQ_PIXEL) || (kind == REQ_FLUSH && !in_frame);
    assign stream_step  = in_xfer && step_ok;
    assign start_filter = step_ok && (pos_reg >= lag_reg);
    assign fe = ((POS_W+1)'(pos_reg) + 1'b1) >= ((POS_W+1)'(total_reg) + (POS_W+1)'(lag_reg));

    assign cfg_w = cfg_data[10:0];
    assign cfg_h = cfg_data[12:0];
    assign cfg_r = cfg_data[2:0];

    // configuration and derived sizes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            radius_reg <= RW'(2);
            pend_reg   <= 1'b1;
        end else begin
            pend_reg <= cfg_we;
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH: begin
                        width_reg <= (cfg_w == '0) ? DIM_W'(1) :
                                     (32'(cfg_w) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) :
                                     DIM_W'(cfg_w);
                    end
                    CFG_HEIGHT: begin
                        height_reg <= (cfg_h == '0) ? DIM_W'(1) :
                                      (32'(cfg_h) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) :
                                      DIM_W'(cfg_h);
                    end
                    CFG_RADIUS: begin
                        radius_reg <= (32'(cfg_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) :
                                      RW'(cfg_r);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= POS_W'(width_reg) * POS_W'(height_reg);
        lag_reg   <= POS_W'(POS_W'(radius_reg) * POS_W'(width_reg) + POS_W'(radius_reg));
    end

    // stream counters
    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_we && cfg_index <= CFG_RADIUS)
                || (stream_step && start_filter && fe)) begin
            pos_reg      <= '0;
            col_reg      <= '0;
            in_ring_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_ring_reg <= '0;
        end else if (stream_step) begin
            pos_reg <= pos_reg + 1'b1;
            if ((DIM_W'(col_reg) + 1'b1) >= width_reg) begin
                col_reg     <= '0;
                in_ring_reg <= (32'(in_ring_reg) == RING - 1) ? '0 : in_ring_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
            if (start_filter) begin
                if ((DIM_W'(out_col_reg) + 1'b1) >= width_reg) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_ring_reg <= (32'(out_ring_reg) == RING - 1) ? '0 :
                                    out_ring_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // tap geometry
    always_comb begin
        dr_x    = {{(SW-DW){dr_reg[DW-1]}}, dr_reg};
        dc_x    = {{(SW-DW){dc_reg[DW-1]}}, dc_reg};
        dr_abs  = (dr_x < 0) ? -dr_x : dr_x;
        dc_abs  = (dc_x < 0) ? -dc_x : dc_x;
        span    = signed'(SW'(radius_reg)) - dr_abs;
        tap_d   = RW'(dr_abs + dc_abs);
        qr      = signed'(SW'(cr_reg)) + dr_x;
        qc      = signed'(SW'(cc_reg)) + dc_x;
        tap_in  = (qr >= 0) && (qr < signed'(SW'(height_reg)))
               && (qc >= 0) && (qc < signed'(SW'(width_reg)));
        ring    = signed'(SW'(cring_reg)) + dr_x;
        ring_w  = (ring < 0) ? ring + SW'(RING) :
                  (ring >= SW'(RING)) ? ring - SW'(RING) : ring;
        tap_addr = AW'(ring_w[RING_W-1:0]) * AW'(MAX_WIDTH) + AW'(qc[CW-1:0]);
        ctr_addr = AW'(cring_reg) * AW'(MAX_WIDTH) + AW'(cc_reg);
        dr1      = dr_x + SW'(1);
        dr1_abs  = (dr1 < 0) ? -dr1 : dr1;
        if (dc_x < span) begin
            dr_next   = dr_reg;
            dc_next   = DW'(dc_x + SW'(1));
            done_next = 1'b0;
        end else begin
            dr_next   = DW'(dr1);
            dc_next   = DW'(dr1_abs - signed'(SW'(radius_reg)));
            done_next = dr1 > signed'(SW'(radius_reg));
        end
        w_full = prod_reg >> WSHIFT;
        w      = (w_full > 32'(WMAX)) ? WEIGHT_BITS'(WMAX) : w_full[WEIGHT_BITS-1:0];
    end

    // line store
    assign ls_waddr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(col_reg);
    assign ls_raddr = (state_reg == ST_CENTER) ? ctr_addr : tap_addr;

    always_ff @(posedge aclk) begin
        if (in_xfer && kind == REQ_PIXEL && in_frame) begin
            ls_mem[ls_waddr] <= s_pixel_in;
        end
        ls_rdata_reg <= ls_mem[ls_raddr];
    end

    // weight tables
    assign rt_raddr = (p_reg > ls_rdata_reg) ? p_reg - ls_rdata_reg : ls_rdata_reg - p_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer && kind == REQ_RANGE) begin
            rt_mem[s_table_index] <= s_weight_value;
        end
        rt_rdata_reg <= rt_mem[rt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && kind == REQ_SPATIAL && 32'(s_table_index) <= MAX_RADIUS) begin
            st_reg[RW'(s_table_index)] <= s_weight_value;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (stream_step && start_filter) state_next = ST_CENTER;
            ST_CENTER: state_next = ST_CWAIT;
            ST_CWAIT:  state_next = ST_TAP;
            ST_TAP: begin
                if (tap_done_reg) begin
                    state_next = ST_DIV;
                end else if (tap_in) begin
                    state_next = ST_QREAD;
                end
            end
            ST_QREAD:  state_next = ST_RREAD;
            ST_RREAD:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_TAP;
            ST_DIV:    if (div_done) state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign div_start = (state_reg == ST_TAP) && tap_done_reg;

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_done_reg <= 1'b0;
        end else if (state_reg == ST_CWAIT) begin
            tap_done_reg <= 1'b0;
        end else if ((state_reg == ST_TAP && !tap_done_reg && !tap_in)
                || state_reg == ST_ACC) begin
            tap_done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stream_step && start_filter) begin
            cr_reg    <= out_row_reg;
            cc_reg    <= out_col_reg;
            cring_reg <= out_ring_reg;
            fe_reg    <= fe;
        end
        unique case (state_reg)
            ST_CWAIT: begin
                p_reg   <= ls_rdata_reg;
                dr_reg  <= -DW'(radius_reg);
                dc_reg  <= '0;
                num_reg <= '0;
                den_reg <= '0;
            end
            ST_TAP: begin
                if (!tap_done_reg) begin
                    if (tap_in) begin
                        d_reg <= tap_d;
                    end else begin
                        dr_reg <= dr_next;
                        dc_reg <= dc_next;
                    end
                end
            end
            ST_QREAD: q_reg <= ls_rdata_reg;
            ST_RREAD: prod_reg <= 32'(st_reg[d_reg]) * 32'(rt_rdata_reg);
            ST_ACC: begin
                num_reg <= num_reg + NUM_W'(w) * NUM_W'(q_reg);
                den_reg <= den_reg + DEN_W'(w);
                dr_reg  <= dr_next;
                dc_reg  <= dc_next;
            end
            ST_DIV: begin
                if (div_done) begin
                    pix_reg  <= (den_reg == '0) ? '0 : div_quo;
                    orow_reg <= cr_reg;
                    ocol_reg <= cc_reg;
                    ofe_reg  <= fe_reg;
                end
            end
            default: ;
        endcase
    end

    bfd_div #(
        .NUM_BITS(NUM_W),
        .DEN_BITS(DEN_W),
        .Q_BITS  (QUO_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (num_reg),
        .den    (den_reg),
        .done   (div_done),
        .quo    (div_quo)
    );

    assign m_valid     = (state_reg == ST_OUT);
    assign m_pixel_out = pix_reg;
    assign m_out_row   = orow_reg;
    assign m_out_col   = 10'(ocol_reg);
    assign m_frame_end = ofe_reg;

endmodule
`default_nettype wire

[rtl/core/bfd_checker.sv]
`default_nettype none
module bfd_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_pixel_out,
    input wire logic [11:0] m_out_row,
    input wire logic [9:0]  m_out_col,
    input wire logic        m_frame_end
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_out_row)
            && $stable(m_out_col) && $stable(m_frame_end))
        else $error("stalled result changed");

    // one item in flight: no input while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready with result pending");

    // after a result transfer the block returns to idle
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result repeated");

    // sizes settle in the cycle after a configuration write, with the input not ready
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input ready right after config write");

    // no result out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bilateral_filter_diamond bfd_props u_bfd_props (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .cfg_we     (cfg_we),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_pixel_out(m_pixel_out),
    .m_out_row  (m_out_row),
    .m_out_col  (m_out_col),
    .m_frame_end(m_frame_end)
);
`default_nettype wire

[tb/bfd_checker.sv]
`default_nettype none
module bfd_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_table_index,
    input  wire logic [15:0] s_weight_value,
    input  wire logic [7:0]  s_pixel_in,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_pixel_out,
    input  wire logic [11:0] m_out_row,
    input  wire logic [9:0]  m_out_col,
    input  wire logic        m_frame_end,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    localparam int RING = 2 * MAX_RADIUS_DEF + 1;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [11:0] row;
        logic [9:0]  col;
        logic        fend;
    } filt_px_t;

    filt_px_t    px_q[$];
    logic [7:0]  lines[RING * MAX_WIDTH_DEF];
    logic [15:0] range_w[256];
    logic [15:0] space_w[MAX_RADIUS_DEF + 1];
    int          fw, fh, fr;
    int          in_row, in_col, stream_pos;
    int          err_cnt;

    function automatic int slot(int r, int c);
        return (r % RING) * MAX_WIDTH_DEF + (c % MAX_WIDTH_DEF);
    endfunction

    function automatic void restart();
        in_row = 0;
        in_col = 0;
        stream_pos = 0;
    endfunction

    function automatic logic [7:0] smooth_at(int cr, int cc);
        longint unsigned num, den, w;
        int a, qr, qc, d;
        logic [7:0] p, q, diff;
        num = 0;
        den = 0;
        p = lines[slot(cr, cc)];
        for (int dr = -fr; dr <= fr; dr++) begin
            a = dr < 0 ? -dr : dr;
            for (int dc = -(fr - a); dc <= fr - a; dc++) begin
                qr = cr + dr;
                qc = cc + dc;
                if (qr < 0 || qc < 0 || qr >= fh || qc >= fw) continue;
                d = a + (dc < 0 ? -dc : dc);
                q = lines[slot(qr, qc)];
                diff = p > q ? p - q : q - p;
                w = (longint'(space_w[d]) * longint'(range_w[diff])) >> WSHIFT;
                if (w > WMAX) w = WMAX;
                num += w * q;
                den += w;
            end
        end
        if (den == 0) return 8'd0;
        num = num / den;
        return num > 255 ? 8'd255 : num[7:0];
    endfunction

    function automatic void write_reg(cfg_idx_t idx, logic [12:0] v);
        case (idx)
            CFG_WIDTH: begin
                fw = v[10:0] == 0 ? 1 : (v[10:0] > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : v[10:0]);
            end
            CFG_HEIGHT: fh = v == 0 ? 1 : (v > MAX_HEIGHT ? MAX_HEIGHT : v);
            CFG_RADIUS: fr = v[2:0] > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : v[2:0];
            default: return;
        endcase
        restart();
    endfunction

    function automatic void take_item(req_t kind, logic [7:0] idx, logic [15:0] wv,
                                      logic [7:0] pix);
        int total, lag, p, cp;
        filt_px_t e;
        total = fw * fh;
        lag = fr * fw + fr;
        case (kind)
            REQ_RANGE: begin
                range_w[idx] = wv;
                return;
            end
            REQ_SPATIAL: begin
                if (idx <= MAX_RADIUS_DEF) space_w[idx] = wv;
                return;
            end
            default: ;
        endcase
        p = stream_pos;
        if (p < total) begin
            if (kind == REQ_FLUSH) return;
            lines[slot(in_row, in_col)] = pix;
        end
        stream_pos = p + 1;
        in_col++;
        if (in_col >= fw) begin
            in_col = 0;
            in_row++;
        end
        if (p < lag) return;
        cp = p - lag;
        e.row = 12'(cp / fw);
        e.col = 10'(cp % fw);
        e.pixel = smooth_at(cp / fw, cp % fw);
        e.fend = cp + 1 >= total;
        px_q.push_back(e);
        if (e.fend) restart();
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    initial begin
        err_cnt = 0;
        errors = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        filt_px_t e;
        if (!aresetn) begin
            fw = 640;
            fh = 480;
            fr = 2;
            foreach (lines[i]) lines[i] = '0;
            foreach (range_w[i]) range_w[i] = '0;
            foreach (space_w[i]) space_w[i] = '0;
            restart();
        end else begin
            if (cfg_we) write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (s_valid && s_ready)
                take_item(req_t'(s_req_type), s_table_index, s_weight_value, s_pixel_in);
            if (m_valid && m_ready) begin
                if (px_q.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual row %0d col %0d",
                             $time, m_out_row, m_out_col);
                    err_cnt++;
                end else begin
                    e = px_q.pop_front();
                    check_field("pixel_out", e.pixel, m_pixel_out);
                    check_field("out_row", e.row, m_out_row);
                    check_field("out_col", e.col, m_out_col);
                    check_field("frame_end", e.fend, m_frame_end);
                end
            end
        end
        pending <= px_q.size();
        errors <= err_cnt;
    end
endmodule
`default_nettype wire

[tb/tb_bilateral_filter_diamond.sv]
`default_nettype none
module tb_bilateral_filter_diamond;
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    localparam int LIMIT = 3_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [7:0]  s_table_index = '0;
    logic [15:0] s_weight_value = '0;
    logic [7:0]  s_pixel_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_pixel_out;
    logic [11:0] m_out_row;
    logic [9:0]  m_out_col;
    logic        m_frame_end;
    int          errors, pending;
    int          cycles = 0;
    int          sent = 0;
    int          hold_left = 0;
    bit          hold_go = 1'b0;
    bit          hold_taken = 1'b0;
    bit          idle_on = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bilateral_filter_diamond i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_req_type, .s_table_index, .s_weight_value, .s_pixel_in,
        .m_valid, .m_ready, .m_pixel_out, .m_out_row, .m_out_col, .m_frame_end
    );

    bfd_checker i_chk (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_req_type, .s_table_index, .s_weight_value, .s_pixel_in,
        .m_valid, .m_ready, .m_pixel_out, .m_out_row, .m_out_col, .m_frame_end,
        .errors, .pending
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 600;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_on || $urandom_range(99) >= 8;
        end
    end

    function automatic logic [7:0] rand_pix();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd32768;
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    task automatic send(req_t kind, logic [7:0] idx, logic [15:0] wv, logic [7:0] pix);
        if (idle_on && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_table_index <= idx;
        s_weight_value <= wv;
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 13'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_load();
        if ($urandom_range(1))
            send(REQ_RANGE, 8'($urandom_range(255)), rand_weight(), rand_pix());
        else
            send(REQ_SPATIAL, 8'($urandom_range(MAX_RADIUS_DEF + 2)), rand_weight(),
                 rand_pix());
    endtask

    // one frame; raw register values, at most max_pix pixels (frame aborted if fewer)
    task automatic run_frame(int w, int h, int r, int max_pix, bit noise);
        int ew, eh, er, total, lag, npix;
        ew = w % 2048 == 0 ? 1 : (w % 2048 > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w % 2048);
        eh = h == 0 ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
        er = r > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : r;
        total = ew * eh;
        lag = er * ew + er;
        npix = total < max_pix ? total : max_pix;
        settle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RADIUS, r);
        for (int i = 0; i < npix; i++) begin
            if (noise && $urandom_range(99) < 6) random_load();
            if (noise && $urandom_range(99) < 4) send(REQ_FLUSH, '0, '0, rand_pix());
            send(REQ_PIXEL, 8'($urandom_range(255)), 16'($urandom_range(65535)), rand_pix());
        end
        if (npix == total) begin
            for (int i = 0; i < lag; i++) begin
                if (noise && $urandom_range(99) < 5) random_load();
                send($urandom_range(3) == 0 ? REQ_PIXEL : REQ_FLUSH,
                     8'($urandom_range(255)), 16'($urandom_range(65535)), rand_pix());
            end
        end
    endtask

    initial begin
        int base;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 256; i++) send(REQ_RANGE, 8'(i), rand_weight(), rand_pix());
        for (int i = 0; i <= MAX_RADIUS_DEF; i++)
            send(REQ_SPATIAL, 8'(i), i == 0 ? 16'd32768 : rand_weight(), rand_pix());
        send(REQ_SPATIAL, 8'd255, 16'hFFFF, 8'hFF);
        send(REQ_SPATIAL, 8'(MAX_RADIUS_DEF + 1), 16'd0, 8'd0);

        run_frame(3, 2, 1, 1 << 30, 1'b1);
        run_frame(0, 0, 0, 1 << 30, 1'b0);
        run_frame(2047, 1, 0, 1 << 30, 1'b0);
        run_frame(0, 8191, 7, 40, 1'b0);
        run_frame(1024, 4096, 4, 12, 1'b0);
        run_frame(9, 9, 4, 1 << 30, 1'b0);
        settle();
        for (int i = 0; i <= MAX_RADIUS_DEF; i++) send(REQ_SPATIAL, 8'(i), '0, '0);
        run_frame(4, 3, 2, 1 << 30, 1'b0);
        for (int i = 0; i <= MAX_RADIUS_DEF; i++)
            send(REQ_SPATIAL, 8'(i), rand_weight(), '0);

        base = sent;
        while (sent < base + 500) begin
            if (sent > base + 60) hold_go <= 1'b1;
            idle_on = !(sent > base + 200 && sent < base + 300);
            run_frame($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 4),
                      $urandom_range(9) == 0 ? $urandom_range(1, 20) : 1 << 30, 1'b1);
        end
        idle_on = 1'b1;

        settle();
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
